// File: hdl/lrup_pkg.sv
package lrup_pkg;

	localparam int FRAMES     = 8;
	localparam int PAGE_BITS  = 16;
	localparam int COUNT_BITS = 32;
	localparam int CFG_BITS   = 4;
	localparam int SLOT_OUT_BITS = 3;
	localparam int SLOT_BITS  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RANK_BITS  = SLOT_BITS;
	localparam logic [CFG_BITS-1:0] FRAMES_RESET = CFG_BITS'(8);
	localparam logic [RANK_BITS-1:0] RANK_MAX = RANK_BITS'(FRAMES - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} lrup_state_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic update;
	} lrup_cmd_t;

endpackage

// File: hdl/lrup_ctrl.sv
module lrup_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output lrup_pkg::lrup_cmd_t cmd
);
	import lrup_pkg::*;

	lrup_state_t state_q;
	lrup_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (start) begin
					state_nxt = ST_LOOKUP;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy       = 1'b0;
		cmd.load   = 1'b0;
		cmd.lookup = 1'b0;
		cmd.update = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_LOOKUP: begin
				busy       = 1'b1;
				cmd.lookup = 1'b1;
			end
			ST_UPDATE: begin
				cmd.load   = start;
				cmd.update = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

// File: hdl/lrup_datapath.sv
module lrup_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lrup_pkg::lrup_cmd_t                  cmd,
	input  logic                                 cfg_we,
	input  logic [lrup_pkg::CFG_BITS-1:0]        cfg_wdata,
	input  logic [lrup_pkg::PAGE_BITS-1:0]       page,
	input  logic                                 first_access,
	input  logic                                 last_access,
	output logic                                 res_valid,
	output logic                                 hit,
	output logic [lrup_pkg::SLOT_OUT_BITS-1:0]   frame_slot,
	output logic [lrup_pkg::COUNT_BITS-1:0]      fault_count,
	output logic                                 done_res
);
	import lrup_pkg::*;

	logic [CFG_BITS-1:0]   frames_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic                  first_q;
	logic                  last_q;

	logic [PAGE_BITS-1:0]  resident_q [FRAMES];
	logic [FRAMES-1:0]     valid_q;
	logic [RANK_BITS-1:0]  rank_q [FRAMES];
	logic [COUNT_BITS-1:0] count_q;

	logic                  hit_s1;
	logic [SLOT_BITS-1:0]  slot_s1;
	logic [RANK_BITS-1:0]  hit_rank_s1;

	logic                  hit_q;
	logic [SLOT_BITS-1:0]  slot_q;
	logic [COUNT_BITS-1:0] fault_q;
	logic                  done_q;
	logic                  res_valid_q;

	logic [FRAMES-1:0]     in_use;
	logic [FRAMES-1:0]     eff_valid;
	logic [RANK_BITS-1:0]  eff_rank [FRAMES];
	logic [FRAMES-1:0]     match;
	logic                  any_match;
	logic [SLOT_BITS-1:0]  match_slot;
	logic                  any_empty;
	logic [SLOT_BITS-1:0]  empty_slot;
	logic [RANK_BITS-1:0]  best_rank;
	logic [SLOT_BITS-1:0]  victim_slot;
	logic [SLOT_BITS-1:0]  sel_slot;

	logic [RANK_BITS-1:0]  rank_nxt [FRAMES];
	logic [FRAMES-1:0]     valid_nxt;
	logic [COUNT_BITS-1:0] count_base;
	logic [COUNT_BITS-1:0] count_nxt;

	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			in_use[i]    = (i == 0) || (int'(frames_q) > i);
			eff_valid[i] = valid_q[i] & ~first_q;
			eff_rank[i]  = first_q ? '0 : rank_q[i];
			match[i]     = in_use[i] & eff_valid[i] & (resident_q[i] == page_q);
		end
	end

	always_comb begin
		any_match  = 1'b0;
		match_slot = '0;
		any_empty  = 1'b0;
		empty_slot = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				any_match  = 1'b1;
				match_slot = SLOT_BITS'(i);
			end
			if (in_use[i] && !eff_valid[i]) begin
				any_empty  = 1'b1;
				empty_slot = SLOT_BITS'(i);
			end
		end
	end

	always_comb begin
		best_rank   = '0;
		victim_slot = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (in_use[i] && (eff_rank[i] > best_rank)) begin
				best_rank   = eff_rank[i];
				victim_slot = SLOT_BITS'(i);
			end
		end
	end

	always_comb begin
		if (any_match) begin
			sel_slot = match_slot;
		end else if (any_empty) begin
			sel_slot = empty_slot;
		end else begin
			sel_slot = victim_slot;
		end
	end

	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			rank_nxt[i]  = eff_rank[i];
			valid_nxt[i] = eff_valid[i];
			if (SLOT_BITS'(i) == slot_s1) begin
				rank_nxt[i] = '0;
				if (!hit_s1) begin
					valid_nxt[i] = 1'b1;
				end
			end else if (in_use[i] && eff_valid[i] && (eff_rank[i] < RANK_MAX)
				&& (!hit_s1 || (eff_rank[i] < hit_rank_s1))) begin
				rank_nxt[i] = eff_rank[i] + RANK_BITS'(1);
			end
		end
		count_base = first_q ? '0 : count_q;
		if (!hit_s1 && (count_base != COUNT_MAX)) begin
			count_nxt = count_base + COUNT_BITS'(1);
		end else begin
			count_nxt = count_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (cfg_we) begin
			frames_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q  <= page;
			first_q <= first_access;
			last_q  <= last_access;
		end
		if (cmd.lookup) begin
			hit_s1      <= any_match;
			slot_s1     <= sel_slot;
			hit_rank_s1 <= eff_rank[sel_slot];
		end
		if (cmd.update) begin
			if (!hit_s1) begin
				resident_q[slot_s1] <= page_q;
			end
			hit_q   <= hit_s1;
			slot_q  <= slot_s1;
			fault_q <= count_nxt;
			done_q  <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			res_valid_q <= cmd.update;
			if (cmd.update) begin
				valid_q <= valid_nxt;
				count_q <= count_nxt;
				for (int i = 0; i < FRAMES; i++) begin
					rank_q[i] <= rank_nxt[i];
				end
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign hit         = hit_q;
	assign frame_slot  = SLOT_OUT_BITS'(slot_q);
	assign fault_count = fault_q;
	assign done_res    = done_q;

endmodule

// File: hdl/lru_page_replacement_top.sv
// A request accepted by the controller goes through the lookup and update steps;
// its result is registered on the outputs for one cycle, marked by res_valid.
// A new request can be accepted during the update step of the previous one.
// The receiver cannot stall, so results are never held back.
// Reset clears all frames, ranks and the fault count, and sets eight frames.
module lru_page_replacement_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [lrup_pkg::PAGE_BITS-1:0]       page,
	input  logic                                 first_access,
	input  logic                                 last_access,
	input  logic                                 cfg_we,
	input  logic [lrup_pkg::CFG_BITS-1:0]        cfg_wdata,
	output logic                                 res_valid,
	output logic                                 hit,
	output logic [lrup_pkg::SLOT_OUT_BITS-1:0]   frame_slot,
	output logic [lrup_pkg::COUNT_BITS-1:0]      fault_count,
	output logic                                 done_res
);
	import lrup_pkg::*;

	lrup_cmd_t cmd;

	lrup_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	lrup_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.page         (page),
		.first_access (first_access),
		.last_access  (last_access),
		.res_valid    (res_valid),
		.hit          (hit),
		.frame_slot   (frame_slot),
		.fault_count  (fault_count),
		.done_res     (done_res)
	);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import lrup_pkg::*;

	typedef struct packed {
		logic                     hit;
		logic [SLOT_OUT_BITS-1:0] slot;
		logic [COUNT_BITS-1:0]    count;
		logic                     done;
	} page_outcome_t;

	logic                     clk;
	logic                     arst_n       = 1'b0;
	logic                     start        = 1'b0;
	logic                     busy;
	logic [PAGE_BITS-1:0]     page         = '0;
	logic                     first_access = 1'b0;
	logic                     last_access  = 1'b0;
	logic                     cfg_we       = 1'b0;
	logic [CFG_BITS-1:0]      cfg_wdata    = '0;
	logic                     res_valid;
	logic                     hit;
	logic [SLOT_OUT_BITS-1:0] frame_slot;
	logic [COUNT_BITS-1:0]    fault_count;
	logic                     done_res;

	// Shadow copy of the frame table, kept in step with accepted requests.
	logic [PAGE_BITS-1:0]  shadow_page [FRAMES];
	logic                  shadow_used [FRAMES];
	logic [RANK_BITS-1:0]  shadow_age  [FRAMES];
	logic [COUNT_BITS-1:0] shadow_faults;
	logic [CFG_BITS-1:0]   shadow_frames;

	page_outcome_t predicted_outcomes[$];
	int errors = 0;
	int requests_sent = 0;
	int outcomes_checked = 0;
	int hits_seen = 0;
	int cfg_writes = 0;
	int sender_idle_pct = 0;

	lru_page_replacement_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.page        (page),
		.first_access(first_access),
		.last_access (last_access),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.res_valid   (res_valid),
		.hit         (hit),
		.frame_slot  (frame_slot),
		.fault_count (fault_count),
		.done_res    (done_res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d outcomes still pending", predicted_outcomes.size());
		$display("Some tests failed");
		$finish;
	end

	function automatic void clear_shadow();
		for (int i = 0; i < FRAMES; i++) begin
			shadow_page[i] = '0;
			shadow_used[i] = 1'b0;
			shadow_age[i]  = '0;
		end
		shadow_faults = '0;
	endfunction

	function automatic page_outcome_t lru_lookup(logic [PAGE_BITS-1:0] p, logic first,
			logic last);
		int n;
		int slot;
		bit found;
		bit empty_found;
		logic [RANK_BITS-1:0] ref_age;
		logic [RANK_BITS-1:0] oldest;
		page_outcome_t res;
		n = shadow_frames;
		if (n < 1) n = 1;
		if (n > FRAMES) n = FRAMES;
		if (first) clear_shadow();
		found = 1'b0;
		slot = 0;
		for (int i = 0; i < n; i++) begin
			if (!found && shadow_used[i] && shadow_page[i] == p) begin
				found = 1'b1;
				slot = i;
			end
		end
		if (found) begin
			ref_age = shadow_age[slot];
			for (int i = 0; i < n; i++)
				if (i != slot && shadow_used[i] && shadow_age[i] < ref_age &&
						shadow_age[i] != RANK_MAX)
					shadow_age[i]++;
		end else begin
			empty_found = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (!empty_found && !shadow_used[i]) begin
					slot = i;
					empty_found = 1'b1;
				end
			end
			if (!empty_found) begin
				oldest = '0;
				slot = 0;
				for (int i = 0; i < n; i++) begin
					if (shadow_age[i] > oldest) begin
						oldest = shadow_age[i];
						slot = i;
					end
				end
			end
			for (int i = 0; i < n; i++)
				if (i != slot && shadow_used[i] && shadow_age[i] != RANK_MAX)
					shadow_age[i]++;
			shadow_page[slot] = p;
			shadow_used[slot] = 1'b1;
			if (shadow_faults != COUNT_MAX) shadow_faults++;
		end
		shadow_age[slot] = '0;
		res.hit   = found;
		res.slot  = SLOT_OUT_BITS'(slot);
		res.count = shadow_faults;
		res.done  = last;
		return res;
	endfunction

	always @(posedge clk) begin
		page_outcome_t want;
		if (arst_n && res_valid) begin
			outcomes_checked++;
			if (hit) hits_seen++;
			if (predicted_outcomes.size() == 0) begin
				if (errors < 10)
					$display("%t: unexpected outcome hit=%0b slot=%0d count=%0d done=%0b",
						$realtime, hit, frame_slot, fault_count, done_res);
				errors++;
			end else begin
				want = predicted_outcomes.pop_front();
				if (hit !== want.hit || frame_slot !== want.slot ||
						fault_count !== want.count || done_res !== want.done) begin
					if (errors < 10)
						$display("%t: mismatch expected hit=%0b slot=%0d count=%0d done=%0b, got hit=%0b slot=%0d count=%0d done=%0b",
							$realtime, want.hit, want.slot, want.count, want.done,
							hit, frame_slot, fault_count, done_res);
					errors++;
				end
			end
		end
	end

	task automatic pause(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_results();
		start <= 1'b0;
		while (predicted_outcomes.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_frames(logic [CFG_BITS-1:0] value);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_frames = value;
		cfg_writes++;
	endtask

	task automatic send_request(logic [PAGE_BITS-1:0] p, logic first, logic last);
		int gap;
		page         <= p;
		first_access <= first;
		last_access  <= last;
		start        <= 1'b1;
		do @(posedge clk); while (busy);
		predicted_outcomes.push_back(lru_lookup(p, first, last));
		requests_sent++;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < sender_idle_pct) gap++;
		if (gap > 0) pause(gap);
	endtask

	task automatic test_directed();
		sender_idle_pct = 0;
		send_request(16'h0000, 1'b1, 1'b0);
		send_request(16'hFFFF, 1'b0, 1'b0);
		for (int i = 1; i <= 6; i++) send_request(PAGE_BITS'(i), 1'b0, 1'b0);
		send_request(16'h0000, 1'b0, 1'b0);
		send_request(16'h0006, 1'b0, 1'b0);
		send_request(16'h0100, 1'b0, 1'b0);
		send_request(16'h0000, 1'b0, 1'b1);
		send_request(16'h0000, 1'b1, 1'b0);
		wait_results();
		write_frames(4'd1);
		send_request(16'h0005, 1'b0, 1'b0);
		send_request(16'h0005, 1'b0, 1'b0);
		send_request(16'h0007, 1'b0, 1'b0);
		wait_results();
		write_frames(4'd0);
		send_request(16'h0007, 1'b0, 1'b0);
		send_request(16'h0009, 1'b0, 1'b0);
		wait_results();
		write_frames(4'd15);
		send_request(16'h8000, 1'b0, 1'b0);
		send_request(16'h0009, 1'b0, 1'b0);
		send_request(16'hAAAA, 1'b0, 1'b1);
		wait_results();
		write_frames(4'd8);
		send_request(16'h5555, 1'b1, 1'b1);
		wait_results();
	endtask

	// Segments run at different frame counts. A segment often continues the
	// previous one without clearing, so frames left outside a smaller count
	// come back with stale ages and possibly duplicate pages.
	task automatic test_random(int idle_pct, int n_items);
		logic [CFG_BITS-1:0] sweep [10] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5,
			4'd2, 4'd7, 4'd6, 4'd4};
		int sent;
		int seg;
		int seg_len;
		int seg_sent;
		int seq_len;
		int pool_size;
		int n;
		bit fresh;
		logic [PAGE_BITS-1:0] pool_base;
		logic [PAGE_BITS-1:0] p;
		logic first;
		logic last;
		sender_idle_pct = idle_pct;
		sent = 0;
		seg = 0;
		pool_base = PAGE_BITS'($urandom);
		while (sent < n_items) begin
			wait_results();
			write_frames((seg < 10) ? sweep[seg] : CFG_BITS'($urandom_range(0, 15)));
			n = shadow_frames;
			if (n < 1) n = 1;
			if (n > FRAMES) n = FRAMES;
			seg++;
			seg_len = $urandom_range(60, 120);
			seg_sent = 0;
			fresh = ($urandom_range(3) == 0);
			if (fresh) pool_base = PAGE_BITS'($urandom);
			pool_size = n + $urandom_range(0, 6);
			while (seg_sent < seg_len && sent < n_items) begin
				seq_len = $urandom_range(3, 40);
				for (int k = 0; k < seq_len && sent < n_items; k++) begin
					if ($urandom_range(99) < 8)
						p = PAGE_BITS'($urandom);
					else
						p = pool_base ^ PAGE_BITS'($urandom_range(0, pool_size - 1));
					if (k == 0)
						first = (seg_sent == 0) ? fresh : ($urandom_range(9) != 0);
					else
						first = ($urandom_range(99) < 2);
					last = (k == seq_len - 1) || ($urandom_range(99) < 2);
					send_request(p, first, last);
					sent++;
					seg_sent++;
					if ($urandom_range(99) < 2) wait_results();
				end
			end
		end
		wait_results();
	endtask

	initial begin
		shadow_frames = FRAMES_RESET;
		clear_shadow();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(18, 510);
		test_random(48, 510);
		test_random(0, 510);
		wait_results();
		if (predicted_outcomes.size() != 0) errors++;
		$display("Sent %0d page references over %0d frame count settings.",
			requests_sent, cfg_writes);
		$display("Checked %0d outcomes, %0d of them hits, with %0d mismatches.",
			outcomes_checked, hits_seen, errors);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: lru_page_replacement_top.f
hdl/lrup_pkg.sv
hdl/lrup_ctrl.sv
hdl/lrup_datapath.sv
hdl/lru_page_replacement_top.sv
tb/testbench.sv
